FILE: hw/rtl/icmp_pkg.sv
// icmp_pkg: sizes, header codes, controller/datapath command and status types,
// and the one's-complement adder of the ICMP echo packet builder.
// No dependencies.
package icmp_pkg;

  localparam int MAX_PAYLOAD_WORDS = 32;   // payload store depth, 1..60
  localparam int HDR_WORDS         = 4;    // type/code, checksum, ident, seq

  localparam int CNT_W  = $clog2(MAX_PAYLOAD_WORDS + 1);
  localparam int ADDR_W = (MAX_PAYLOAD_WORDS > 1) ? $clog2(MAX_PAYLOAD_WORDS) : 1;
  localparam int IDX_W  = $clog2(MAX_PAYLOAD_WORDS + HDR_WORDS + 1);

  localparam logic [7:0] TYPE_REQUEST = 8'd8;
  localparam logic [7:0] TYPE_REPLY   = 8'd0;
  localparam logic [7:0] CODE_ECHO    = 8'd0;

  // byte_count codes
  localparam logic [1:0] BC_EMPTY = 2'd0;
  localparam logic [1:0] BC_HIGH  = 2'd1;

  // emitted word positions
  localparam int W_TYPE  = 0;
  localparam int W_CSUM  = 1;
  localparam int W_IDENT = 2;
  localparam int W_SEQ   = 3;

  // header words folded into the sum, one per step
  localparam int STEP_TYPE  = 0;
  localparam int STEP_IDENT = 1;
  localparam int STEP_SEQ   = 2;
  localparam int SUM_STEPS  = 3;

  typedef struct packed {
    logic take;      // input beat accepted
    logic sum_step;  // fold one header word into the sum
    logic emit;      // load next packet word into output register
    logic close;     // final word loaded, clear packet state
  } icmp_cmd_t;

  typedef struct packed {
    logic last_seen; // accepted beat carries last_word
    logic sum_done;  // last header fold this cycle
    logic out_free;  // output register can take a word
    logic is_eop;    // current emit index is the final word
  } icmp_sts_t;

  // 16-bit one's-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: hw/rtl/icmp_if.sv
// icmp_if: valid/ready channel interfaces for payload input beats and
// packet output beats. No dependencies.
interface icmp_in_if;
  logic        valid;
  logic        ready;
  logic        echo_reply;
  logic [15:0] identifier;
  logic [15:0] sequence_num;
  logic [15:0] data_word;
  logic [1:0]  byte_count;
  logic        last_word;

  modport source (output valid, output echo_reply, output identifier, output sequence_num,
                  output data_word, output byte_count, output last_word, input ready);
  modport sink   (input valid, input echo_reply, input identifier, input sequence_num,
                  input data_word, input byte_count, input last_word, output ready);
endinterface

interface icmp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_word;
  logic        end_of_packet;
  logic        overflow;

  modport source (output valid, output packet_word, output end_of_packet,
                  output overflow, input ready);
  modport sink   (input valid, input packet_word, input end_of_packet,
                  input overflow, output ready);
endinterface

FILE: hw/rtl/icmp_ctrl.sv
// icmp_ctrl: collect / checksum / emit sequencer of the ICMP echo builder.
// Depends on icmp_pkg.
module icmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  icmp_pkg::icmp_sts_t sts,
  output icmp_pkg::icmp_cmd_t cmd
);
  import icmp_pkg::*;

  typedef enum logic [2:0] {
    S_COLLECT = 3'b001,
    S_SUM     = 3'b010,
    S_EMIT    = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd          = '0;
    in_ready     = (state_r == S_COLLECT);
    cmd.take     = in_valid && in_ready;
    cmd.sum_step = (state_r == S_SUM);
    cmd.emit     = (state_r == S_EMIT) && sts.out_free;
    cmd.close    = cmd.emit && sts.is_eop;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_COLLECT: if (sts.last_seen) state_nxt = S_SUM;
      S_SUM:     if (sts.sum_done)  state_nxt = S_EMIT;
      S_EMIT:    if (cmd.close)     state_nxt = S_COLLECT;
      default:   state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // input side and output loading never overlap
  a_take_vs_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take && cmd.emit))
    else $error("input beat taken while emitting");

endmodule

FILE: hw/rtl/icmp_dpath.sv
// icmp_dpath: header latches, payload store, one's-complement sum, emit index
// and output register of the ICMP echo builder. Depends on icmp_pkg.
module icmp_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  icmp_pkg::icmp_cmd_t cmd,
  output icmp_pkg::icmp_sts_t sts,
  input  logic                echo_reply,
  input  logic [15:0]         identifier,
  input  logic [15:0]         sequence_num,
  input  logic [15:0]         data_word,
  input  logic [1:0]          byte_count,
  input  logic                last_word,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [15:0]         packet_word,
  output logic                end_of_packet,
  output logic                overflow
);
  import icmp_pkg::*;

  logic [15:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             reply_r, inpkt_r, inpkt_nxt, drop_r, drop_nxt;
  logic [15:0]      ident_r, seq_r;
  logic [15:0]      mem [MAX_PAYLOAD_WORDS];
  logic [15:0]      rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_word_r;
  logic             out_eop_r, out_ovf_r;

  logic [15:0]      in_w, w0, hdr_add, emit_word;
  logic             has_word, room, store_en, sum_done, is_eop, out_free;
  logic [IDX_W-1:0] pofs;
  logic [ADDR_W-1:0] rd_addr;

  assign in_w     = (byte_count == BC_HIGH) ? {data_word[15:8], 8'h00} : data_word;
  assign has_word = (byte_count != BC_EMPTY);
  assign room     = (cnt_r < CNT_W'(MAX_PAYLOAD_WORDS));
  assign store_en = cmd.take && has_word && room;
  assign w0       = {(reply_r ? TYPE_REPLY : TYPE_REQUEST), CODE_ECHO};
  assign sum_done = (idx_r == IDX_W'(SUM_STEPS - 1));
  assign is_eop   = ((idx_r + IDX_W'(1)) == (IDX_W'(HDR_WORDS) + IDX_W'(cnt_r)));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    case (idx_r)
      IDX_W'(STEP_TYPE):  hdr_add = w0;
      IDX_W'(STEP_IDENT): hdr_add = ident_r;
      IDX_W'(STEP_SEQ):   hdr_add = seq_r;
      default:            hdr_add = 16'h0000;
    endcase
  end

  always_comb begin
    case (idx_r)
      IDX_W'(W_TYPE):  emit_word = w0;
      IDX_W'(W_CSUM):  emit_word = ~sum_r;
      IDX_W'(W_IDENT): emit_word = ident_r;
      IDX_W'(W_SEQ):   emit_word = seq_r;
      default:         emit_word = rd_data_r;
    endcase
  end

  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    inpkt_nxt = inpkt_r;
    idx_nxt   = idx_r;
    if (cmd.take) begin
      inpkt_nxt = 1'b1;
      if (store_en) begin
        sum_nxt = oc_add(sum_r, in_w);
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (has_word) begin
        drop_nxt = 1'b1;
      end
    end
    if (cmd.sum_step) begin
      sum_nxt = oc_add(sum_r, hdr_add);
      idx_nxt = sum_done ? '0 : idx_r + IDX_W'(1);
    end
    if (cmd.emit) begin
      idx_nxt = is_eop ? '0 : idx_r + IDX_W'(1);
    end
    if (cmd.close) begin
      sum_nxt   = '0;
      cnt_nxt   = '0;
      drop_nxt  = 1'b0;
      inpkt_nxt = 1'b0;
    end
  end

  // read address follows the next emit index, so rd_data_r holds the
  // payload word of the current index
  always_comb begin
    pofs    = idx_nxt - IDX_W'(HDR_WORDS);
    rd_addr = (pofs < IDX_W'(MAX_PAYLOAD_WORDS)) ? pofs[ADDR_W-1:0] : '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (store_en) mem[cnt_r[ADDR_W-1:0]] <= in_w;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r <= emit_word;
      out_eop_r  <= is_eop;
      out_ovf_r  <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      drop_r      <= 1'b0;
      inpkt_r     <= 1'b0;
      reply_r     <= 1'b0;
      ident_r     <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      drop_r      <= drop_nxt;
      inpkt_r     <= inpkt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.take && !inpkt_r) begin
        reply_r <= echo_reply;
        ident_r <= identifier;
        seq_r   <= sequence_num;
      end
    end
  end

  always_comb begin
    sts           = '0;
    sts.last_seen = cmd.take && last_word;
    sts.sum_done  = sum_done;
    sts.out_free  = out_free;
    sts.is_eop    = is_eop;
  end

  assign out_valid     = out_valid_r;
  assign packet_word   = out_word_r;
  assign end_of_packet = out_eop_r;
  assign overflow      = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PAYLOAD_WORDS))
    else $error("payload count beyond store depth");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (cnt_r == CNT_W'(MAX_PAYLOAD_WORDS)))
    else $error("words dropped with room in store");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.close |=> (cnt_r == '0) && !drop_r && !inpkt_r && (idx_r == '0))
    else $error("packet state not cleared after final word");

endmodule

FILE: hw/rtl/icmp_echo_packet_builder.sv
// ICMP echo builder top: beats are taken back to back; after the last beat input
// stalls through the three checksum folds and the emission of all 4 + payload words.
// First word is registered for output after the folds, then 1 word/cycle with ready.
// rst_n is synchronous, active low; clears control state, payload store not cleared.
// Depends on icmp_pkg, icmp_if, icmp_ctrl, icmp_dpath.
module icmp_echo_packet_builder (
  input  logic      clk,
  input  logic      rst_n,
  icmp_in_if.sink   in_ch,
  icmp_out_if.source out_ch
);
  import icmp_pkg::*;

  // Controller owns the handshake on the input side and the sequence:
  //   collect beats -> fold type/code, ident, seq into the sum -> emit words.
  // Datapath keeps the payload store (one write port during collect, one
  // registered read during emit), the end-around-carry sum and the output
  // register, which decouples the output ready from the input side.
  icmp_cmd_t cmd;
  icmp_sts_t sts;

  icmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Payload beat words land in the store in arrival order; words past the
  // store depth are dropped and set the overflow mark for the whole packet.
  icmp_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .echo_reply    (in_ch.echo_reply),
    .identifier    (in_ch.identifier),
    .sequence_num  (in_ch.sequence_num),
    .data_word     (in_ch.data_word),
    .byte_count    (in_ch.byte_count),
    .last_word     (in_ch.last_word),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .packet_word   (out_ch.packet_word),
    .end_of_packet (out_ch.end_of_packet),
    .overflow      (out_ch.overflow)
  );

endmodule
